>>> rtl/core/frc_pkg.sv
// Package for the fuzzy relation composer: constants, codes, and shared types.
// Has no dependencies. Every module in rtl/core imports it.
package frc_pkg;

  localparam int unsigned DefMaxRows  = 16;
  localparam int unsigned DefMaxInner = 16;
  localparam int unsigned DefMaxCols  = 16;

  localparam logic [16:0] QOne = 17'd32768;

  localparam logic [1:0] CmdLoadA   = 2'd0;
  localparam logic [1:0] CmdLoadB   = 2'd1;
  localparam logic [1:0] CmdCompute = 2'd2;

  localparam logic [2:0] RegTnorm   = 3'd0;
  localparam logic [2:0] RegTconorm = 3'd1;
  localparam logic [2:0] RegRows    = 3'd2;
  localparam logic [2:0] RegInner   = 3'd3;
  localparam logic [2:0] RegCols    = 3'd4;

  localparam logic [2:0] ModeMin      = 3'd0;
  localparam logic [2:0] ModeProd     = 3'd1;
  localparam logic [2:0] ModeBounded  = 3'd2;
  localparam logic [2:0] ModeDrastic  = 3'd3;
  localparam logic [2:0] ModeEinstein = 3'd4;
  localparam logic [2:0] ModeHamacher = 3'd5;
  localparam logic [2:0] ModeNilpot   = 3'd6;

  typedef enum logic [2:0] {
    StIdle, StRead, StNorm, StNormDiv, StConorm, StConormDiv, StOut
  } frc_state_e;

  // Request handed to the divider: numerator and divisor.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [17:0] den;
  } frc_div_req_t;

  // 17-bit saturate to 1.0.
  function automatic logic [16:0] qsat(input logic [31:0] v);
    qsat = (v > 32'(QOne)) ? QOne : v[16:0];
  endfunction

endpackage

>>> rtl/core/frc_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit numerator.
// Depends on frc_pkg for the request struct.
module frc_div
  import frc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  frc_div_req_t req_i,
  output logic         done_o,
  output logic [31:0]  quot_o
);

  logic [31:0] quot_q, quot_d;
  logic [17:0] rem_q, rem_d;
  logic [17:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [18:0] trial;

  // One shift and subtract per cycle.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[31]};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = 18'(trial - {1'b0, den_q});
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial[17:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (req_i.start) den_q <= req_i.den;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = quot_d;

endmodule

>>> rtl/core/fuzzy_relation_composer.sv
// Fuzzy sup-T composition of two relations held in on-chip memories, Q1.15.
// Load words are taken one per cycle while no compute word is in progress. A
// compute word walks n = min(inner_count, MAX_INNER) inner steps, each through
// the read, t-norm and t-conorm states. The first step only seeds the fold.
// Einstein and Hamacher modes can send the t-norm of each step and the t-conorm
// of each step after the first through the divider. The input is ready again in
// the cycle that the result word becomes valid. A cell outside the configured or
// maximum sizes skips the inner steps. A result word held by the receiver stalls
// the input only once the next compute word has finished. Stores are undefined
// until written.
module fuzzy_relation_composer
  import frc_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = DefMaxRows,
  parameter int unsigned MAX_INNER = DefMaxInner,
  parameter int unsigned MAX_COLS  = DefMaxCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  row_index_i,
  input  logic [3:0]  col_index_i,
  input  logic [15:0] member_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_value_o,
  output logic [3:0]  result_row_o,
  output logic [3:0]  result_col_o,
  output logic        index_error_o
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned KW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned NW = $clog2(MAX_INNER + 1);
  localparam int unsigned AAW =
    (MAX_ROWS * MAX_INNER > 1) ? $clog2(MAX_ROWS * MAX_INNER) : 1;
  localparam int unsigned BAW =
    (MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1;

  // Configuration registers.
  logic [2:0] tn_q, tc_q;
  logic [4:0] rows_q, inner_q, cols_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tn_q <= ModeMin; tc_q <= ModeMin;
      rows_q <= 5'd16; inner_q <= 5'd16; cols_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegTnorm:   tn_q    <= cfg_data_i[2:0];
        RegTconorm: tc_q    <= cfg_data_i[2:0];
        RegRows:    rows_q  <= cfg_data_i;
        RegInner:   inner_q <= cfg_data_i;
        RegCols:    cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Relation memories.
  logic [15:0] mem_a [MAX_ROWS*MAX_INNER];
  logic [15:0] mem_b [MAX_INNER*MAX_COLS];
  logic [15:0] rd_a_q, rd_b_q;

  frc_state_e st_q, st_d;
  logic [3:0]  row_q, col_q;
  logic [NW-1:0] k_q, k_d, n_w;
  logic [16:0] acc_q, acc_d, t_q, t_d;
  logic        ov_q, ov_d, err_q, err_d;
  logic [15:0] res_q;
  logic [3:0]  orow_q, ocol_q;
  logic        oerr_q;
  logic        out_load;
  frc_div_req_t dreq;
  logic        ddone;
  logic [31:0] dquot;

  logic accept;
  assign in_ready_o = (st_q == StIdle);
  assign accept = in_valid_i && in_ready_o;

  // Fold length, saturated at the store depth.
  assign n_w = (32'(inner_q) > MAX_INNER) ? NW'(MAX_INNER) : NW'(inner_q);

  logic [16:0] vin;
  assign vin = qsat({16'd0, member_value_i});

  logic [KW-1:0] k_idx;
  assign k_idx = k_q[KW-1:0];

  // Writes on loads, reads each inner step.
  always_ff @(posedge clk_i) begin
    if (accept && command_i == CmdLoadA && 32'(row_index_i) < MAX_ROWS
        && 32'(col_index_i) < MAX_INNER)
      mem_a[AAW'(RW'(row_index_i) * MAX_INNER + KW'(col_index_i))] <= vin[15:0];
    if (accept && command_i == CmdLoadB && 32'(row_index_i) < MAX_INNER
        && 32'(col_index_i) < MAX_COLS)
      mem_b[BAW'(KW'(row_index_i) * MAX_COLS + CW'(col_index_i))] <= vin[15:0];
    rd_a_q <= mem_a[AAW'(RW'(row_q) * MAX_INNER + k_idx)];
    rd_b_q <= mem_b[BAW'(k_idx * MAX_COLS + CW'(col_q))];
  end

  // Operator datapath.
  logic [16:0] a, b, ca, cb;
  logic [33:0] pn, pc;
  logic [17:0] sn, sc;
  assign a  = {1'b0, rd_a_q};
  assign b  = {1'b0, rd_b_q};
  assign pn = (34'(a) * 34'(b)) >> 15;
  assign sn = 18'(a) + 18'(b);
  assign ca = acc_q;
  assign cb = t_q;
  assign pc = (34'(ca) * 34'(cb)) >> 15;
  assign sc = 18'(ca) + 18'(cb);

  frc_div u_div (
    .clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot)
  );

  // The finished cell moves to the output register once that is free.
  assign out_load = (st_q == StOut) && (!ov_q || out_ready_i);

  // Sequencer.
  always_comb begin
    logic [17:0] d;
    logic [16:0] p16, pc16;
    st_d = st_q; k_d = k_q; acc_d = acc_q; t_d = t_q;
    ov_d = ov_q; err_d = err_q;
    dreq = '0;
    d = '0;
    p16  = pn[16:0];
    pc16 = pc[16:0];
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        k_d = '0; acc_d = '0;
        if (accept && command_i == CmdCompute) begin
          if ({1'b0, row_index_i} >= rows_q || {1'b0, col_index_i} >= cols_q
              || 32'(row_index_i) >= MAX_ROWS || 32'(col_index_i) >= MAX_COLS) begin
            err_d = 1'b1; st_d = StOut;
          end else begin
            err_d = 1'b0;
            st_d = (n_w == '0) ? StOut : StRead;
          end
        end
      end
      StRead: st_d = StNorm;
      StNorm: begin
        st_d = StConorm;
        case (tn_q)
          ModeProd: t_d = p16;
          ModeBounded: t_d = (sn > 18'(QOne)) ? 17'(sn - 18'(QOne)) : '0;
          ModeDrastic: t_d = (a >= QOne - 17'd1) ? b :
                             (b >= QOne - 17'd1) ? a : '0;
          ModeEinstein: begin
            d = 18'(2 * QOne) - (sn - 18'(p16));
            if (d == '0) t_d = '0;
            else begin dreq = '{1'b1, 32'(p16) << 15, d}; st_d = StNormDiv; end
          end
          ModeHamacher: begin
            d = sn - 18'(p16);
            if (d == '0) t_d = '0;
            else begin dreq = '{1'b1, 32'(p16) << 15, d}; st_d = StNormDiv; end
          end
          ModeNilpot: t_d = (sn > 18'(QOne)) ? ((a < b) ? a : b) : '0;
          default: t_d = (a < b) ? a : b;
        endcase
      end
      StNormDiv: if (ddone) begin t_d = qsat(dquot); st_d = StConorm; end
      StConorm: begin
        st_d = StRead;
        k_d = k_q + NW'(1);
        if (k_q == '0) acc_d = t_q;
        else begin
          case (tc_q)
            ModeProd: acc_d = qsat(32'(sc - 18'(pc16)));
            ModeBounded: acc_d = qsat(32'(sc));
            ModeDrastic: acc_d = (ca <= 17'd1) ? cb : (cb <= 17'd1) ? ca : QOne;
            ModeEinstein: begin
              dreq = '{1'b1, 32'(sc) << 15, 18'(QOne) + 18'(pc16)};
              st_d = StConormDiv; k_d = k_q;
            end
            ModeHamacher: begin
              d = 18'(QOne) - 18'(pc16);
              if (d == '0 || pc16 > QOne) acc_d = QOne;
              else begin
                dreq = '{1'b1, 32'(sc - 18'(2 * pc16)) << 15, d};
                st_d = StConormDiv; k_d = k_q;
              end
            end
            ModeNilpot: acc_d = (sc < 18'(QOne)) ? ((ca > cb) ? ca : cb) : QOne;
            default: acc_d = (ca > cb) ? ca : cb;
          endcase
        end
        if (st_d == StRead && k_d == n_w) st_d = StOut;
      end
      StConormDiv: if (ddone) begin
        acc_d = qsat(dquot);
        k_d = k_q + NW'(1);
        st_d = (k_d == n_w) ? StOut : StRead;
      end
      StOut: begin
        if (out_load) begin ov_d = 1'b1; st_d = StIdle; end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ov_q <= 1'b0; k_q <= '0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; t_q <= t_d; err_q <= err_d;
    if (accept) begin row_q <= row_index_i; col_q <= col_index_i; end
    if (out_load) begin
      res_q <= acc_q[15:0]; orow_q <= row_q; ocol_q <= col_q; oerr_q <= err_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign result_value_o = res_q;
  assign result_row_o   = orow_q;
  assign result_col_o   = ocol_q;
  assign index_error_o  = oerr_q;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the fuzzy relation composer.
// Depends on frc_pkg and fuzzy_relation_composer; predicts each result word from
// its own copy of both relations and configuration registers, or a directed row.
module tb
  import frc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  row;
    logic [3:0]  col;
    logic        err;
  } cell_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] member;
    bit          typed;
    logic [15:0] typed_value;
    logic        typed_err;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [4:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  logic [3:0]  row_index_i;
  logic [3:0]  col_index_i;
  logic [15:0] member_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] result_value_o;
  logic [3:0]  result_row_o;
  logic [3:0]  result_col_o;
  logic        index_error_o;

  fuzzy_relation_composer dut (.*);

  // Shadow state of the block.
  logic [15:0] shadow_a [16][16];
  logic [15:0] shadow_b [16][16];
  logic [2:0]  norm_sel, conorm_sel;
  logic [4:0]  rows_cfg, inner_cfg, cols_cfg;

  cell_result_t pending_cells[$];
  stim_row_t    directed_rows[$];
  int           fail_count;
  int           send_idle, recv_idle;
  bit           hold_req;
  int           hold_left;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] sat_one(logic [31:0] v);
    return (v > 32'd32768) ? 32'd32768 : v;
  endfunction

  function automatic logic [31:0] norm_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] p, d;
    p = (a * b) >> 15;
    case (norm_sel)
      ModeProd:    return p;
      ModeBounded: return (a + b > 32'd32768) ? a + b - 32'd32768 : 32'd0;
      ModeDrastic: begin
        if (a >= 32'd32767) return b;
        if (b >= 32'd32767) return a;
        return 32'd0;
      end
      ModeEinstein: begin
        d = 32'd65536 - (a + b - p);
        if (d < 32'd1) return 32'd0;
        return sat_one((p * 32'd32768) / d);
      end
      ModeHamacher: begin
        d = a + b - p;
        if (d < 32'd1) return 32'd0;
        return sat_one((p * 32'd32768) / d);
      end
      ModeNilpot: return (a + b > 32'd32768) ? ((a < b) ? a : b) : 32'd0;
      default:    return (a < b) ? a : b;
    endcase
  endfunction

  function automatic logic [31:0] conorm_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] p, d;
    p = (a * b) >> 15;
    case (conorm_sel)
      ModeProd:    return sat_one(a + b - p);
      ModeBounded: return sat_one(a + b);
      ModeDrastic: begin
        if (a <= 32'd1) return b;
        if (b <= 32'd1) return a;
        return 32'd32768;
      end
      ModeEinstein: return sat_one(((a + b) * 32'd32768) / (32'd32768 + p));
      ModeHamacher: begin
        d = 32'd32768 - p;
        if (d < 32'd1) return 32'd32768;
        return sat_one(((a + b - 2 * p) * 32'd32768) / d);
      end
      ModeNilpot: return (a + b < 32'd32768) ? ((a > b) ? a : b) : 32'd32768;
      default:    return (a > b) ? a : b;
    endcase
  endfunction

  // Applies one accepted word to the shadow state; returns 1 with the
  // expected result when the word is a compute.
  function automatic bit predict_word(logic [1:0] cmd, logic [3:0] r, logic [3:0] c,
                                      logic [15:0] v, output cell_result_t res);
    logic [31:0] acc, term;
    int          n;
    res = '0;
    if (cmd == CmdLoadA) begin
      shadow_a[r][c] = 16'(sat_one({16'd0, v}));
      return 0;
    end
    if (cmd == CmdLoadB) begin
      shadow_b[r][c] = 16'(sat_one({16'd0, v}));
      return 0;
    end
    if (cmd != CmdCompute) return 0;
    res.row = r;
    res.col = c;
    if (r >= rows_cfg || c >= cols_cfg) begin
      res.err = 1'b1;
      return 1;
    end
    n = (inner_cfg > 16) ? 16 : inner_cfg;
    acc = 0;
    for (int k = 0; k < n; k++) begin
      term = norm_of({16'd0, shadow_a[r][k]}, {16'd0, shadow_b[k][c]});
      acc = (k == 0) ? term : conorm_of(acc, term);
    end
    res.value = acc[15:0];
    return 1;
  endfunction

  // Register write, mirrored into the shadow configuration; the enable stays
  // high until the caller drops it.
  task automatic write_reg(logic [2:0] idx, logic [4:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      RegTnorm:   norm_sel   = data[2:0];
      RegTconorm: conorm_sel = data[2:0];
      RegRows:    rows_cfg   = data;
      RegInner:   inner_cfg  = data;
      RegCols:    cols_cfg   = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [2:0] tn, logic [2:0] tc, logic [4:0] nr,
                           logic [4:0] ni, logic [4:0] nc);
    write_reg(RegTnorm, {2'b00, tn});
    write_reg(RegTconorm, {2'b00, tc});
    write_reg(RegRows, nr);
    write_reg(RegInner, ni);
    write_reg(RegCols, nc);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one word; returns at the falling edge after it was accepted,
  // with valid still high.
  task automatic send_word(stim_row_t w);
    cell_result_t exp_res;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= w.cmd;
    row_index_i    <= w.row;
    col_index_i    <= w.col;
    member_value_i <= w.member;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_word(w.cmd, w.row, w.col, w.member, exp_res)) begin
      if (w.typed) begin
        exp_res.value = w.typed_value;
        exp_res.err   = w.typed_err;
      end
      pending_cells.push_back(exp_res);
    end
    @(negedge clk_i);
  endtask

  // Lets the block drain before the configuration changes.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_cells.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic stim_row_t make_row(logic [1:0] cmd, logic [3:0] r, logic [3:0] c,
                                         logic [15:0] v, bit typed = 0,
                                         logic [15:0] tv = 0, logic te = 0);
    stim_row_t s;
    s.cmd = cmd; s.row = r; s.col = c; s.member = v;
    s.typed = typed; s.typed_value = tv; s.typed_err = te;
    return s;
  endfunction

  // Membership degree leaning towards the corner values.
  function automatic logic [15:0] pick_degree();
    logic [15:0] corners [8] = '{16'd0, 16'd1, 16'd2, 16'd32766, 16'd32767,
                                 16'd32768, 16'd32769, 16'hFFFF};
    if ($urandom_range(0, 2) == 0) return corners[$urandom_range(0, 7)];
    if ($urandom_range(0, 4) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [3:0] pick_index(logic [4:0] limit);
    if (limit == 0 || $urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, (limit > 16 ? 16 : limit) - 1));
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: result word with nothing expected, got value %0d row %0d col %0d",
                 $time, result_value_o, result_row_o, result_col_o);
        fail_count++;
      end else begin
        want = pending_cells.pop_front();
        if (result_value_o !== want.value) begin
          $display("%0t: result_value expected %0d got %0d", $time, want.value,
                   result_value_o);
          fail_count++;
        end
        if (result_row_o !== want.row) begin
          $display("%0t: result_row expected %0d got %0d", $time, want.row, result_row_o);
          fail_count++;
        end
        if (result_col_o !== want.col) begin
          $display("%0t: result_col expected %0d got %0d", $time, want.col, result_col_o);
          fail_count++;
        end
        if (index_error_o !== want.err) begin
          $display("%0t: index_error expected %0d got %0d", $time, want.err,
                   index_error_o);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    stim_row_t w;
    logic [4:0] nr, ni, nc;
    int         pick;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; command_i = '0; row_index_i = '0; col_index_i = '0;
    member_value_i = '0; hold_req = 0; fail_count = 0;
    send_idle = 13; recv_idle = 75;
    norm_sel = ModeMin; conorm_sel = ModeMin;
    rows_cfg = 5'd16; inner_cfg = 5'd16; cols_cfg = 5'd16;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part on a small 4x2x4 setting so only loaded entries are read.
    write_all(ModeMin, ModeMin, 5'd4, 5'd2, 5'd4);
    directed_rows.push_back(make_row(CmdLoadA, 0, 0, 16'hFFFF));
    directed_rows.push_back(make_row(CmdLoadA, 0, 1, 16'd0));
    directed_rows.push_back(make_row(CmdLoadB, 0, 0, 16'd32768));
    directed_rows.push_back(make_row(CmdLoadB, 1, 0, 16'd12345));
    directed_rows.push_back(make_row(2'd3, 4'd15, 4'd15, 16'hFFFF));
    directed_rows.push_back(make_row(CmdCompute, 0, 0, 0, 1, 16'd32768, 1'b0));
    directed_rows.push_back(make_row(CmdCompute, 15, 15, 16'hFFFF, 1, 16'd0, 1'b1));
    directed_rows.push_back(make_row(CmdCompute, 4, 0, 0, 1, 16'd0, 1'b1));
    directed_rows.push_back(make_row(CmdCompute, 0, 4, 0, 1, 16'd0, 1'b1));
    directed_rows.push_back(make_row(CmdLoadA, 1, 0, 16'd1));
    directed_rows.push_back(make_row(CmdLoadA, 1, 1, 16'd32767));
    directed_rows.push_back(make_row(CmdLoadB, 0, 1, 16'd32769));
    directed_rows.push_back(make_row(CmdLoadB, 1, 1, 16'h5555));
    directed_rows.push_back(make_row(CmdCompute, 1, 1, 0));
    directed_rows.push_back(make_row(CmdCompute, 1, 0, 0));
    directed_rows.push_back(make_row(CmdCompute, 0, 1, 0));
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    // Fill both relations completely so later computes never read an empty entry.
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) begin
        send_word(make_row(CmdLoadA, 4'(r), 4'(c), pick_degree()));
        send_word(make_row(CmdLoadB, 4'(r), 4'(c), pick_degree()));
      end
    wait_idle();

    // Random phases, each under its own setting, extremes first.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin nr = 16; ni = 16; nc = 16; end
        1: begin nr = 1;  ni = 0;  nc = 1;  end
        2: begin nr = 31; ni = 31; nc = 31; end
        3: begin nr = 0;  ni = 1;  nc = 0;  end
        default: begin
          nr = 5'($urandom_range(0, 31));
          ni = 5'($urandom_range(0, 4));
          nc = 5'($urandom_range(0, 31));
        end
      endcase
      if (ph >= 8) begin
        send_idle = 0; recv_idle = 0;
      end else if (ph >= 4) begin
        send_idle = 75; recv_idle = 13;
      end
      write_all(3'(ph % 8), 3'((ph * 5) % 8), nr, ni, nc);
      if (ph == 8) hold_req = 1;
      for (int n = 0; n < 60; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          w = make_row(CmdCompute, pick_index(rows_cfg), pick_index(cols_cfg),
                       16'($urandom()));
        else if (pick < 95)
          w = make_row(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), pick_degree());
        else
          w = make_row(2'd3, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       16'($urandom()));
        send_word(w);
      end
      wait_idle();
    end

    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending_cells.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
